// File: sv/ewm_pkg.sv
// ============================================================================
// ewm_pkg
// Shared types, constants and the sine table of the enveloped waveform mixer.
// ============================================================================
`default_nettype none

package ewm_pkg;

    localparam int FRAME_BITS       = 24;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_BITS        = $clog2(SINE_TABLE_DEPTH);
    localparam int BOUND_W          = 24;
    localparam int TW               = (FRAME_BITS > BOUND_W) ? FRAME_BITS : BOUND_W;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_INDEX_W      = 3;

    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_SAW      = 3'd1;
    localparam logic [2:0] WAVE_SQUARE   = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_NOISE    = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_KIND   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOTE_START  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_END  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUSTAIN_END = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOTE_END    = 3'd7;

    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [15:0] NOISE_SEED = 16'h0001;
    localparam logic [16:0] UNITY_Q16  = 17'h10000;
    localparam logic [16:0] FULL_SCALE = 17'd32768;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] SC1     = 64'd1686629713;
    localparam logic [63:0] SC3     = 64'd693598670;
    localparam logic [63:0] SC5     = 64'd85569306;
    localparam logic [63:0] SC7     = 64'd5026995;
    localparam logic [63:0] SC9     = 64'd172273;

    typedef struct packed {
        logic [15:0] mix_left;
        logic [15:0] mix_right;
    } frame_t;

    typedef struct packed {
        logic [15:0] out_left;
        logic [15:0] out_right;
        logic        voice_active;
    } result_t;

    typedef enum logic [1:0] {
        DIV_SAW,
        DIV_ATTACK,
        DIV_DECAY
    } div_sel_t;

    typedef enum logic [1:0] {
        MUL_ENV,
        MUL_AMP,
        MUL_WAVE
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     div_init;
        logic     div_step;
        logic     div_last;
        div_sel_t div_sel;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    typedef logic signed [16:0] sine_tab_t [SINE_TABLE_DEPTH];

    // Polynomial sine of one table entry, folded by the quadrant bits.
    function automatic logic signed [16:0] sine_entry(input int unsigned k);
        logic [31:0] angle;
        logic [1:0]  quad;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] q;
        logic [16:0] mag;
        angle = 32'(k) << (32 - SINE_BITS);
        quad  = angle[31:30];
        t     = {34'd0, angle[29:0]};
        if (quad[0])
            t = Q30_ONE - t;
        t2  = (t * t) >> 30;
        acc = SC9;
        acc = SC7 - ((acc * t2) >> 30);
        acc = SC5 - ((acc * t2) >> 30);
        acc = SC3 - ((acc * t2) >> 30);
        acc = SC1 - ((acc * t2) >> 30);
        s   = (acc * t) >> 30;
        q   = (s + 64'd16384) >> 15;
        if (q > 64'd32767)
            q = 64'd32767;
        mag = {1'b0, q[15:0]};
        return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic sine_tab_t build_sine_lut();
        sine_tab_t tab;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
            tab[k] = sine_entry(k);
        return tab;
    endfunction

    localparam sine_tab_t SINE_LUT = build_sine_lut();

endpackage

`default_nettype wire

// File: sv/ewm_control.sv
// ============================================================================
// ewm_control
// Sequencer: capture, three shared divisions, three multiplies, commit.
// ============================================================================
`default_nettype none

module ewm_control (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                frame_valid,
    output logic                     frame_ready,
    output ewm_pkg::dp_cmd_t         cmd,
    input  wire ewm_pkg::dp_status_t status
);
    import ewm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_INIT,
        S_DIV_RUN,
        S_MUL,
        S_FINISH
    } state_t;

    state_t      state_reg;
    div_sel_t    sel_reg;
    mul_sel_t    msel_reg;
    logic [3:0]  cnt_reg;

    assign frame_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.div_sel  = sel_reg;
        cmd.mul_sel  = msel_reg;
        cmd.capture  = (state_reg == S_IDLE) && frame_valid;
        cmd.div_init = (state_reg == S_DIV_INIT);
        cmd.div_step = (state_reg == S_DIV_RUN);
        cmd.div_last = (state_reg == S_DIV_RUN) && (cnt_reg == 4'd15);
        cmd.mul_en   = (state_reg == S_MUL);
        cmd.commit   = (state_reg == S_FINISH) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= DIV_SAW;
            msel_reg  <= MUL_ENV;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (frame_valid)
                    begin
                        sel_reg   <= DIV_SAW;
                        state_reg <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV_RUN;
                end
                S_DIV_RUN:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        case (sel_reg)
                            DIV_SAW:
                            begin
                                sel_reg   <= DIV_ATTACK;
                                state_reg <= S_DIV_INIT;
                            end
                            DIV_ATTACK:
                            begin
                                sel_reg   <= DIV_DECAY;
                                state_reg <= S_DIV_INIT;
                            end
                            default:
                            begin
                                msel_reg  <= MUL_ENV;
                                state_reg <= S_MUL;
                            end
                        endcase
                    end
                end
                S_MUL:
                begin
                    case (msel_reg)
                        MUL_ENV: msel_reg <= MUL_AMP;
                        MUL_AMP: msel_reg <= MUL_WAVE;
                        default: state_reg <= S_FINISH;
                    endcase
                end
                S_FINISH:
                begin
                    if (status.out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/ewm_datapath.sv
// ============================================================================
// ewm_datapath
// Configuration, oscillator state, shared divider and multiplier, output word.
// ============================================================================
`default_nettype none

module ewm_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [ewm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [ewm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire ewm_pkg::frame_t                      frame_data,
    output logic                                      result_valid,
    input  wire logic                                 result_ready,
    output ewm_pkg::result_t                          result_data,
    input  wire ewm_pkg::dp_cmd_t                     cmd,
    output ewm_pkg::dp_status_t                       status
);
    import ewm_pkg::*;

    localparam int DW = BOUND_W;

    // Configuration registers.
    logic [2:0]         kind_reg;
    logic [14:0]        amp_reg;
    logic [15:0]        period_reg;
    logic [31:0]        step_reg;
    logic [BOUND_W-1:0] start_reg;
    logic [BOUND_W-1:0] att_end_reg;
    logic [BOUND_W-1:0] sus_end_reg;
    logic [BOUND_W-1:0] note_end_reg;

    // Oscillator state.
    logic [FRAME_BITS-1:0] frame_reg;
    logic [31:0]           phase_reg;
    logic [15:0]           pos_reg;
    logic [15:0]           noise_reg;

    // Captured frame.
    logic [15:0]        left_reg;
    logic [15:0]        right_reg;
    logic [TW-1:0]      n_reg;
    logic [15:0]        p_reg;
    logic [15:0]        per_reg;
    logic [2:0]         kind_item_reg;
    logic               active_reg;
    logic               in_attack_reg;
    logic               in_decay_reg;
    logic [15:0]        noise_item_reg;
    logic signed [16:0] sine_reg;

    // Arithmetic.
    logic [DW:0]   rem_reg;
    logic [15:0]   quo_reg;
    logic [15:0]   saw_q_reg;
    logic [16:0]   att_reg;
    logic [16:0]   dec_reg;
    logic [32:0]   prod_reg;

    logic    result_valid_reg;
    result_t result_reg;

    logic [15:0]   per_c;
    logic [15:0]   p_c;
    logic [16:0]   p_inc;
    logic [15:0]   pos_next;
    logic [15:0]   noise_next;
    logic [TW-1:0] n_ext;
    logic          active_c;

    assign per_c      = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign p_c        = (pos_reg < per_c) ? pos_reg : 16'd0;
    assign p_inc      = {1'b0, p_c} + 17'd1;
    assign pos_next   = (p_inc >= {1'b0, per_c}) ? 16'd0 : p_inc[15:0];
    assign noise_next = {1'b0, noise_reg[15:1]} ^ (noise_reg[0] ? LFSR_TAPS : 16'd0);
    assign n_ext      = TW'(frame_reg);
    assign active_c   = (n_ext >= TW'(start_reg)) && (n_ext < TW'(note_end_reg))
                        && (kind_reg <= WAVE_NOISE);

    // Divider operands: the numerator is always below the divisor when the
    // quotient is used, so sixteen restoring steps give it exactly.
    logic [DW-1:0] div_x;
    logic [DW-1:0] div_d;
    logic [DW:0]   rem_sh;
    logic          rem_ge;
    logic [DW:0]   rem_new;
    logic [15:0]   quo_new;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_SAW:
            begin
                div_x = DW'(p_reg);
                div_d = DW'(per_reg);
            end
            DIV_ATTACK:
            begin
                div_x = DW'(n_reg - TW'(start_reg));
                div_d = att_end_reg - start_reg;
            end
            DIV_DECAY:
            begin
                div_x = DW'(n_reg - TW'(sus_end_reg));
                div_d = note_end_reg - sus_end_reg;
            end
            default:
            begin
                div_x = '0;
                div_d = '0;
            end
        endcase
    end

    assign rem_sh  = {rem_reg[DW-1:0], 1'b0};
    assign rem_ge  = (rem_sh >= {1'b0, div_d});
    assign rem_new = rem_ge ? (rem_sh - {1'b0, div_d}) : rem_sh;
    assign quo_new = {quo_reg[14:0], rem_ge};

    // Wave value as sign and magnitude (magnitude up to 32768).
    logic        w_neg;
    logic [16:0] w_mag;
    logic [16:0] saw_abs;
    logic [17:0] tri_dbl;

    assign saw_abs = saw_q_reg[15] ? {2'b00, saw_q_reg[14:0]}
                                   : (FULL_SCALE - {1'b0, saw_q_reg});
    assign tri_dbl = {saw_abs, 1'b0};

    always_comb
    begin
        case (kind_item_reg)
            WAVE_SINE:
            begin
                w_neg = sine_reg[16];
                w_mag = sine_reg[16] ? 17'(-sine_reg) : 17'(sine_reg);
            end
            WAVE_SAW:
            begin
                w_neg = ~saw_q_reg[15];
                w_mag = saw_abs;
            end
            WAVE_SQUARE:
            begin
                w_neg = ~(p_reg < {1'b0, per_reg[15:1]});
                w_mag = FULL_SCALE;
            end
            WAVE_TRIANGLE:
            begin
                w_neg = (saw_abs < 17'd16384);
                w_mag = w_neg ? 17'({1'b0, FULL_SCALE} - tri_dbl)
                              : 17'(tri_dbl - {1'b0, FULL_SCALE});
            end
            default:
            begin
                w_neg = noise_item_reg[15];
                w_mag = noise_item_reg[15] ? (UNITY_Q16 - {1'b0, noise_item_reg})
                                           : {1'b0, noise_item_reg};
            end
        endcase
    end

    // Shared 33 x 17 multiplier.
    logic [32:0] mul_a;
    logic [16:0] mul_b;
    logic [49:0] mul_p;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_ENV:
            begin
                mul_a = 33'(att_reg);
                mul_b = dec_reg;
            end
            MUL_AMP:
            begin
                mul_a = prod_reg;
                mul_b = 17'(amp_reg);
            end
            default:
            begin
                mul_a = prod_reg;
                mul_b = w_mag;
            end
        endcase
    end

    assign mul_p = 50'(mul_a) * 50'(mul_b);

    logic [15:0] voice;
    assign voice = !active_reg ? 16'd0
                 : (w_neg ? (16'd0 - prod_reg[15:0]) : prod_reg[15:0]);

    // Control state: configuration, oscillator state and the output flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg         <= WAVE_SINE;
            amp_reg          <= '0;
            period_reg       <= 16'd1;
            step_reg         <= '0;
            start_reg        <= '0;
            att_end_reg      <= '0;
            sus_end_reg      <= '0;
            note_end_reg     <= '0;
            frame_reg        <= '0;
            phase_reg        <= '0;
            pos_reg          <= '0;
            noise_reg        <= NOISE_SEED;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WAVE_KIND:   kind_reg     <= cfg_data[2:0];
                    CFG_AMPLITUDE:   amp_reg      <= cfg_data[14:0];
                    CFG_PERIOD:      period_reg   <= cfg_data[15:0];
                    CFG_PHASE_STEP:  step_reg     <= cfg_data[31:0];
                    CFG_NOTE_START:  start_reg    <= cfg_data[BOUND_W-1:0];
                    CFG_ATTACK_END:  att_end_reg  <= cfg_data[BOUND_W-1:0];
                    CFG_SUSTAIN_END: sus_end_reg  <= cfg_data[BOUND_W-1:0];
                    CFG_NOTE_END:    note_end_reg <= cfg_data[BOUND_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.capture)
            begin
                frame_reg <= frame_reg + FRAME_BITS'(1);
                phase_reg <= phase_reg + step_reg;
                pos_reg   <= pos_next;
                noise_reg <= noise_next;
            end
            if (cmd.commit)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            left_reg       <= frame_data.mix_left;
            right_reg      <= frame_data.mix_right;
            n_reg          <= n_ext;
            p_reg          <= p_c;
            per_reg        <= per_c;
            kind_item_reg  <= kind_reg;
            active_reg     <= active_c;
            in_attack_reg  <= (n_ext < TW'(att_end_reg));
            in_decay_reg   <= (n_ext > TW'(sus_end_reg));
            noise_item_reg <= noise_reg;
            sine_reg       <= SINE_LUT[phase_reg[31 -: SINE_BITS]];
        end
        if (cmd.div_init)
        begin
            rem_reg <= {1'b0, div_x};
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_new;
            quo_reg <= quo_new;
        end
        if (cmd.div_last)
        begin
            case (cmd.div_sel)
                DIV_SAW:    saw_q_reg <= quo_new;
                DIV_ATTACK: att_reg   <= in_attack_reg ? {1'b0, quo_new} : UNITY_Q16;
                default:    dec_reg   <= in_decay_reg ? (UNITY_Q16 - {1'b0, quo_new})
                                                      : UNITY_Q16;
            endcase
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MUL_ENV: prod_reg <= mul_p[32:0];
                MUL_AMP: prod_reg <= mul_p[47:15];
                default: prod_reg <= 33'(mul_p[49:32]);
            endcase
        end
        if (cmd.commit)
        begin
            result_reg.out_left     <= left_reg + voice;
            result_reg.out_right    <= right_reg + voice;
            result_reg.voice_active <= active_reg;
        end
    end

    assign result_valid    = result_valid_reg;
    assign result_data     = result_reg;
    assign status.out_free = !result_valid_reg || result_ready;

endmodule

`default_nettype wire

// File: sv/enveloped_waveform_mixer.sv
// ============================================================================
// enveloped_waveform_mixer
// Adds one enveloped oscillator voice to a stream of stereo frames.
// ============================================================================
//  channel   direction  handshake                      word
//  frame     in         frame_valid / frame_ready      frame_data (mix_left, mix_right)
//  result    out        result_valid / result_ready    result_data (out_left, out_right,
//                                                        voice_active)
//  config    in         cfg_we                         cfg_index, cfg_data
//
// Each frame goes through the accepting cycle, three passes through the shared
// restoring divider (saw, attack, decay), three passes through the shared
// multiplier and a commit step. The result word is offered from the commit edge on,
// and the next frame can be taken while that word is still being offered.
// After reset the block is idle and ready at once; there is no clearing pass.
// A result word waiting on result_ready holds the sequencer in its last step;
// the next frame is taken in the cycle after the result register is loaded.
`default_nettype none

module enveloped_waveform_mixer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ewm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ewm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            frame_valid,
    output logic                                 frame_ready,
    input  wire ewm_pkg::frame_t                 frame_data,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output ewm_pkg::result_t                     result_data
);
    import ewm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ewm_control u_control (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .cmd         (cmd),
        .status      (status)
    );

    ewm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_data   (frame_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

// File: sv/ewm_checker.sv
// ============================================================================
// ewm_checker
// Port-level checks of the mixer, bound to the top level.
// ============================================================================
`default_nettype none

module ewm_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             frame_valid,
    input wire logic             frame_ready,
    input wire logic             result_valid,
    input wire logic             result_ready,
    input wire ewm_pkg::result_t result_data
);

    // A stalled result word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_data))
        else $error("result word changed while stalled");

    // An accepted frame keeps frame_ready low in the cycles right after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready |=> !frame_ready ##1 !frame_ready)
        else $error("frame taken while the previous one is in progress");

    // A new result appears only at the end of a frame's work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!frame_ready))
        else $error("result appeared without a frame in progress");

endmodule

bind enveloped_waveform_mixer ewm_checker u_ewm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);

`default_nettype wire
